/* rtl/rkes_pkg.sv */
// ----------------------------------------------------------------------------
// rkes_pkg
// Shared types and constants for the record key exchange sorter.
// ----------------------------------------------------------------------------
package rkes_pkg;

  localparam int unsigned Depth    = 32;
  localparam int unsigned KeyWidth = 32;
  localparam int unsigned TagWidth = 16;

  // One stored record: key and tag side by side in a single RAM word
  typedef struct packed {
    logic signed [KeyWidth-1:0] key;
    logic [TagWidth-1:0]        tag;
  } rec_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_GET_I,
    ST_INNER,
    ST_WR_I,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

  typedef enum logic {
    WR_IN,
    WR_HELD
  } wr_sel_e;

  // Control from the sequencer to the datapath and the ports
  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    take_held;
    logic    in_ready;
    logic    out_valid;
    logic    final_item;
    logic    overflowed;
  } ctrl_t;

endpackage

/* rtl/rkes_if.sv */
// ----------------------------------------------------------------------------
// rkes_in_if / rkes_out_if
// Valid/ready channels for incoming records and sorted results.
// ----------------------------------------------------------------------------
interface rkes_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rkes_pkg::KeyWidth-1:0]  key;
  logic [rkes_pkg::TagWidth-1:0]         tag;
  logic                                  is_last;

  modport source (output valid, key, tag, is_last, input ready);
  modport sink   (input valid, key, tag, is_last, output ready);
endinterface

interface rkes_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rkes_pkg::KeyWidth-1:0]  sorted_key;
  logic [rkes_pkg::TagWidth-1:0]         sorted_tag;
  logic                                  final_item;
  logic                                  overflowed;

  modport source (output valid, sorted_key, sorted_tag, final_item, overflowed,
                  input ready);
  modport sink   (input valid, sorted_key, sorted_tag, final_item, overflowed,
                  output ready);
endinterface

/* rtl/rkes_ram.sv */
// ----------------------------------------------------------------------------
// rkes_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rkes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rkes_ctrl.sv */
// ----------------------------------------------------------------------------
// rkes_ctrl
// Sequencer: batch loading, outer/inner exchange loop, result emission.
// ----------------------------------------------------------------------------
module rkes_ctrl #(
  parameter int unsigned DEPTH = rkes_pkg::Depth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_last_i,
  input  logic                     out_ready_i,
  input  logic                     swap_i,
  output rkes_pkg::ctrl_t          ctrl_o,
  output logic [$clog2(DEPTH)-1:0] rd_addr_o,
  output logic [$clog2(DEPTH)-1:0] wr_addr_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;

  rkes_pkg::state_e state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             drop_q, drop_d;
  logic [AW-1:0]    i_q, i_d;
  logic [AW-1:0]    j_q, j_d;
  logic [AW-1:0]    k_q, k_d;

  logic [CW-1:0]    i_next_w;
  logic [CW-1:0]    j_next_w;
  logic [CW-1:0]    k_next_w;

  assign i_next_w = {1'b0, i_q} + CW'(1);
  assign j_next_w = {1'b0, j_q} + CW'(1);
  assign k_next_w = {1'b0, k_q} + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rkes_pkg::ST_LOAD;
      fill_q  <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    drop_d    = drop_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    ctrl_o    = '0;
    ctrl_o.wr_sel     = rkes_pkg::WR_IN;
    ctrl_o.overflowed = drop_q;
    rd_addr_o = i_q;
    wr_addr_o = fill_q[AW-1:0];

    unique case (state_q)
      rkes_pkg::ST_LOAD: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          if (fill_q < CW'(DEPTH)) begin
            ctrl_o.wr_en = 1'b1;
            fill_d       = fill_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_last_i) begin
            i_d     = '0;
            state_d = rkes_pkg::ST_RD_I;
          end
        end
      end
      rkes_pkg::ST_RD_I: begin
        // Outer loop ends when no entry follows position i
        if (i_next_w >= fill_q) begin
          k_d     = '0;
          state_d = rkes_pkg::ST_EMIT_RD;
        end else begin
          ctrl_o.rd_en = 1'b1;
          rd_addr_o    = i_q;
          state_d      = rkes_pkg::ST_GET_I;
        end
      end
      rkes_pkg::ST_GET_I: begin
        ctrl_o.take_held = 1'b1;
        ctrl_o.rd_en     = 1'b1;
        rd_addr_o        = i_next_w[AW-1:0];
        j_d              = i_next_w[AW-1:0];
        state_d          = rkes_pkg::ST_INNER;
      end
      rkes_pkg::ST_INNER: begin
        // Entry j is on the read data; write back the held record on a swap
        ctrl_o.wr_en     = swap_i;
        ctrl_o.wr_sel    = rkes_pkg::WR_HELD;
        ctrl_o.take_held = swap_i;
        wr_addr_o        = j_q;
        if (j_next_w == fill_q) begin
          state_d = rkes_pkg::ST_WR_I;
        end else begin
          ctrl_o.rd_en = 1'b1;
          rd_addr_o    = j_next_w[AW-1:0];
          j_d          = j_next_w[AW-1:0];
        end
      end
      rkes_pkg::ST_WR_I: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_sel = rkes_pkg::WR_HELD;
        wr_addr_o     = i_q;
        i_d           = i_next_w[AW-1:0];
        state_d       = rkes_pkg::ST_RD_I;
      end
      rkes_pkg::ST_EMIT_RD: begin
        ctrl_o.rd_en = 1'b1;
        rd_addr_o    = k_q;
        state_d      = rkes_pkg::ST_EMIT;
      end
      rkes_pkg::ST_EMIT: begin
        ctrl_o.out_valid  = 1'b1;
        ctrl_o.final_item = (k_next_w == fill_q);
        if (out_ready_i) begin
          if (k_next_w == fill_q) begin
            fill_d  = '0;
            drop_d  = 1'b0;
            state_d = rkes_pkg::ST_LOAD;
          end else begin
            ctrl_o.rd_en = 1'b1;
            rd_addr_o    = k_next_w[AW-1:0];
            k_d          = k_next_w[AW-1:0];
          end
        end
      end
      default: begin
        state_d = rkes_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

/* rtl/record_key_exchange_sort.sv */
// ----------------------------------------------------------------------------
// record_key_exchange_sort
// Loads a batch of key/tag records, exchange-sorts it by signed key in a
// RAM and emits the batch in ascending order.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  in_i    | in  | valid/ready   | key, tag, is_last
//  out_o   | out | valid/ready   | sorted_key, sorted_tag, final_item, overflowed
//
// Loading takes a record whenever one is offered. After the last record the
// sort makes one compare per cycle in its inner loop against the single read
// port of the record RAM. Emission then primes the read in a state of its own
// and presents the results in order, reading the next one as each is taken.
// Input is not ready from the last record until the final result is taken.
// Output stalls hold the result word; reset returns to loading, empty batch.
// ----------------------------------------------------------------------------
module record_key_exchange_sort #(
  parameter int unsigned DEPTH = rkes_pkg::Depth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rkes_in_if.sink    in_i,
  rkes_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  rkes_pkg::ctrl_t ctrl;
  rkes_pkg::rec_t  held_q, held_d;
  rkes_pkg::rec_t  rd_rec;
  rkes_pkg::rec_t  in_rec;
  rkes_pkg::rec_t  wr_rec;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            swap;

  assign in_rec.key = in_i.key;
  assign in_rec.tag = in_i.tag;

  // Held record is entry i of the outer loop; swap when it exceeds entry j
  assign swap   = held_q.key > rd_rec.key;
  assign held_d = ctrl.take_held ? rd_rec : held_q;
  assign wr_rec = (ctrl.wr_sel == rkes_pkg::WR_HELD) ? held_q : in_rec;

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  rkes_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.is_last),
    .out_ready_i (out_o.ready),
    .swap_i      (swap),
    .ctrl_o      (ctrl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr)
  );

  rkes_ram #(
    .WIDTH ($bits(rkes_pkg::rec_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_rec),
    .re_i    (ctrl.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_rec)
  );

  assign in_i.ready       = ctrl.in_ready;
  assign out_o.valid      = ctrl.out_valid;
  assign out_o.sorted_key = rd_rec.key;
  assign out_o.sorted_tag = rd_rec.tag;
  assign out_o.final_item = ctrl.final_item;
  assign out_o.overflowed = ctrl.overflowed;

endmodule

/* rtl/rkes_checker.sv */
// ----------------------------------------------------------------------------
// rkes_checker
// Port-level checks on the sorter's load/emit sequencing.
// ----------------------------------------------------------------------------
module rkes_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 in_last_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [rkes_pkg::KeyWidth-1:0] out_key_i,
  input logic [rkes_pkg::TagWidth-1:0]        out_tag_i,
  input logic                                 out_final_i
);

  // Stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_key_i)
      && $stable(out_tag_i) && $stable(out_final_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("loading and emitting at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input taken after last record");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_final_i |=> out_valid_i)
    else $error("batch emission broke off before final word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_final_i |=> !out_valid_i && in_ready_i)
    else $error("no return to loading after final word");

endmodule

bind record_key_exchange_sort rkes_checker u_rkes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.is_last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_key_i   (out_o.sorted_key),
  .out_tag_i   (out_o.sorted_tag),
  .out_final_i (out_o.final_item)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives batches of key/tag records into the exchange sorter and checks every
// sorted word against a local ascending exchange sort of the same batch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned RandomItems = 320;

  localparam logic signed [rkes_pkg::KeyWidth-1:0] MinKey =
    {1'b1, {(rkes_pkg::KeyWidth-1){1'b0}}};
  localparam logic signed [rkes_pkg::KeyWidth-1:0] MaxKey =
    {1'b0, {(rkes_pkg::KeyWidth-1){1'b1}}};

  typedef struct {
    rkes_pkg::rec_t rec;
    logic           final_item;
    logic           overflowed;
  } sorted_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rkes_in_if  in_if ();
  rkes_out_if out_if ();

  record_key_exchange_sort u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rkes_pkg::rec_t batch_q[$];
  logic           batch_dropped = 1'b0;
  sorted_word_t   sorted_q[$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Ascending exchange sort: i upward, j from i+1, swap on signed greater
  function automatic void sort_batch();
    rkes_pkg::rec_t held;
    for (int i = 0; i < batch_q.size(); i++) begin
      for (int j = i + 1; j < batch_q.size(); j++) begin
        if ($signed(batch_q[i].key) > $signed(batch_q[j].key)) begin
          held       = batch_q[i];
          batch_q[i] = batch_q[j];
          batch_q[j] = held;
        end
      end
    end
  endfunction

  function automatic void predict_record(
    input logic signed [rkes_pkg::KeyWidth-1:0] new_key,
    input logic [rkes_pkg::TagWidth-1:0]        new_tag,
    input logic                                 last
  );
    rkes_pkg::rec_t r;
    sorted_word_t   w;
    r.key = new_key;
    r.tag = new_tag;
    // drop once the store is full, the last record too
    if (batch_q.size() < rkes_pkg::Depth) batch_q.push_back(r);
    else batch_dropped = 1'b1;
    if (last) begin
      sort_batch();
      foreach (batch_q[k]) begin
        w.rec        = batch_q[k];
        w.final_item = (k == batch_q.size() - 1);
        w.overflowed = batch_dropped;
        sorted_q.push_back(w);
      end
      batch_q.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  task automatic check_word();
    sorted_word_t w;
    if (sorted_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word key=%0d tag=%h",
                                out_if.sorted_key, out_if.sorted_tag));
      return;
    end
    w = sorted_q.pop_front();
    if (out_if.sorted_key !== w.rec.key)
      report_mismatch($sformatf("sorted_key %0d, want %0d", out_if.sorted_key, w.rec.key));
    if (out_if.sorted_tag !== w.rec.tag)
      report_mismatch($sformatf("sorted_tag %h, want %h", out_if.sorted_tag, w.rec.tag));
    if (out_if.final_item !== w.final_item)
      report_mismatch($sformatf("final_item %b, want %b", out_if.final_item, w.final_item));
    if (out_if.overflowed !== w.overflowed)
      report_mismatch($sformatf("overflowed %b, want %b", out_if.overflowed, w.overflowed));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        predict_record(in_if.key, in_if.tag, in_if.is_last);
      if (out_if.valid && out_if.ready)
        check_word();
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_record(input logic signed [rkes_pkg::KeyWidth-1:0] new_key,
                             input logic [rkes_pkg::TagWidth-1:0]        new_tag,
                             input logic                                 last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.key     <= new_key;
    in_if.tag     <= new_tag;
    in_if.is_last <= last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Hold off the sender until every sorted word has been taken
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sorted_q.size() != 0);
  endtask

  function automatic logic signed [rkes_pkg::KeyWidth-1:0] pick_key();
    case ($urandom_range(7))
      0: return ($urandom_range(1) == 0) ? MinKey : MaxKey;
      1, 2: return int'($urandom_range(8)) - 4;
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_batch_size();
    case ($urandom_range(19))
      0: return rkes_pkg::Depth + $urandom_range(1, 3);
      1: return $urandom_range(rkes_pkg::Depth - 3, rkes_pkg::Depth);
      2, 3: return 1;
      default: return $urandom_range(2, 10);
    endcase
  endfunction

  task automatic send_batch(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_record(pick_key(), rkes_pkg::TagWidth'($urandom_range(16'hFFFF)), i == n - 1);
  endtask

  task automatic test_extremes();
    send_record(MaxKey,        16'hFFFF, 1'b0);
    send_record(MinKey,        16'h0000, 1'b0);
    send_record(32'sd0,        16'hAAAA, 1'b0);
    send_record(-32'sd1,       16'h5555, 1'b0);
    send_record(32'sd1,        16'h8000, 1'b0);
    send_record(32'sh5555_5555, 16'h0001, 1'b0);
    send_record(32'shAAAA_AAAA, 16'h7FFF, 1'b1);
    // single-record batch
    send_record(MinKey,        16'h8001, 1'b1);
    wait_drained();
  endtask

  task automatic test_ties();
    send_record(32'sd5,  16'd1, 1'b0);
    send_record(-32'sd3, 16'd2, 1'b0);
    send_record(32'sd5,  16'd3, 1'b0);
    send_record(32'sd5,  16'd4, 1'b0);
    send_record(-32'sd3, 16'd5, 1'b0);
    send_record(32'sd0,  16'd6, 1'b1);
    wait_drained();
  endtask

  task automatic test_presorted();
    send_record(-32'sd7, 16'h0010, 1'b0);
    send_record(32'sd2,  16'h0011, 1'b0);
    send_record(32'sd9,  16'h0012, 1'b1);
    send_record(32'sd9,  16'h0020, 1'b0);
    send_record(32'sd2,  16'h0021, 1'b0);
    send_record(-32'sd7, 16'h0022, 1'b0);
    send_record(MinKey,  16'h0023, 1'b1);
    wait_drained();
  endtask

  task automatic test_overflow();
    // exactly full, then full with both plain and last records dropped
    send_batch(rkes_pkg::Depth);
    send_batch(rkes_pkg::Depth + 2);
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned n;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < RandomItems / 3) begin
        n = pick_batch_size();
        send_batch(n);
        sent += n;
        if ($urandom_range(7) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.key     <= '0;
    in_if.tag     <= '0;
    in_if.is_last <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 59;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_ties();
    test_presorted();
    test_overflow();
    test_random();

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sorted_q.size() != 0)
      report_mismatch($sformatf("%0d sorted words never arrived", sorted_q.size()));
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rkes_pkg.sv
rtl/rkes_if.sv
rtl/rkes_ram.sv
rtl/rkes_ctrl.sv
rtl/record_key_exchange_sort.sv
rtl/rkes_checker.sv
dv/tb_top.sv
